// ----- sv/mieu_pkg.sv -----
package mieu_pkg;

    localparam int OP_W = 6;
    localparam int WORD_W = 32;
    localparam int IMM_W = 16;
    localparam int SH_W = 5;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 72;
    localparam int DIV_STEPS = 32;
    localparam int LAST_STAGE = DIV_STEPS + 1;

    localparam logic [OP_W-1:0] OP_ADDU   = 6'd0;
    localparam logic [OP_W-1:0] OP_AND    = 6'd1;
    localparam logic [OP_W-1:0] OP_OR     = 6'd2;
    localparam logic [OP_W-1:0] OP_SLTU   = 6'd3;
    localparam logic [OP_W-1:0] OP_SUBU   = 6'd4;
    localparam logic [OP_W-1:0] OP_XOR    = 6'd5;
    localparam logic [OP_W-1:0] OP_ADD    = 6'd6;
    localparam logic [OP_W-1:0] OP_ADDI   = 6'd7;
    localparam logic [OP_W-1:0] OP_ADDIU  = 6'd8;
    localparam logic [OP_W-1:0] OP_ANDI   = 6'd9;
    localparam logic [OP_W-1:0] OP_LUI    = 6'd10;
    localparam logic [OP_W-1:0] OP_ORI    = 6'd11;
    localparam logic [OP_W-1:0] OP_XORI   = 6'd12;
    localparam logic [OP_W-1:0] OP_SLL    = 6'd13;
    localparam logic [OP_W-1:0] OP_SLT    = 6'd14;
    localparam logic [OP_W-1:0] OP_SRA    = 6'd15;
    localparam logic [OP_W-1:0] OP_SRAV   = 6'd16;
    localparam logic [OP_W-1:0] OP_SRL    = 6'd17;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd18;
    localparam logic [OP_W-1:0] OP_BEQ    = 6'd19;
    localparam logic [OP_W-1:0] OP_BGEZ   = 6'd20;
    localparam logic [OP_W-1:0] OP_BLTZ   = 6'd21;
    localparam logic [OP_W-1:0] OP_BGTZ   = 6'd22;
    localparam logic [OP_W-1:0] OP_BLEZ   = 6'd23;
    localparam logic [OP_W-1:0] OP_BNE    = 6'd24;
    localparam logic [OP_W-1:0] OP_BGEZAL = 6'd25;
    localparam logic [OP_W-1:0] OP_BLTZAL = 6'd26;
    localparam logic [OP_W-1:0] OP_SLTI   = 6'd27;
    localparam logic [OP_W-1:0] OP_SLTIU  = 6'd28;
    localparam logic [OP_W-1:0] OP_SLLV   = 6'd29;
    localparam logic [OP_W-1:0] OP_SRLV   = 6'd30;
    localparam logic [OP_W-1:0] OP_DIV    = 6'd31;
    localparam logic [OP_W-1:0] OP_DIVU   = 6'd32;
    localparam logic [OP_W-1:0] OP_MULT   = 6'd33;
    localparam logic [OP_W-1:0] OP_MULTU  = 6'd34;
    localparam logic [OP_W-1:0] OP_JR     = 6'd35;

    localparam logic [1:0] KIND_ALU = 2'd0;
    localparam logic [1:0] KIND_MUL = 2'd1;
    localparam logic [1:0] KIND_DIV = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] operand_s;
        logic [WORD_W-1:0] operand_t;
        logic [IMM_W-1:0]  immediate;
        logic [SH_W-1:0]   shift_amount;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic              cond;
        logic              ovf;
        logic              neg_q;
        logic              neg_r;
        logic [WORD_W:0]   rem;
        logic [WORD_W-1:0] divisor;
    } stage_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
    } front_stat_t;

    function automatic logic [1:0] classify(input logic [OP_W-1:0] op,
                                            input logic [WORD_W-1:0] t);
        logic [1:0] k;
        k = KIND_ALU;
        if (op == OP_MULT || op == OP_MULTU)
            k = KIND_MUL;
        else if ((op == OP_DIV || op == OP_DIVU) && t != '0)
            k = KIND_DIV;
        return k;
    endfunction

endpackage

// ----- sv/mips_integer_execute_unit.sv -----
// channel   dir  tdata fields (lsb first)
// s_axis    in   operation[5:0] operand_s[37:6] operand_t[69:38] immediate[85:70]
//                shift_amount[90:86]
// m_axis    out  result_low[31:0] result_high[63:32] condition_true[64] overflow[65]
// one transfer accepted per cycle while the input queue is not full
// the path runs through the input queue, a decode stage, 32 divide steps and a sign fixup stage
// a two-entry input queue keeps taking transfers until it is full while results are stalled
// m_axis stall freezes the whole pipeline; rst_n clears queue and valid bits
module mips_integer_execute_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation, operand_s, operand_t, immediate, shift_amount
    input  logic [mieu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_low, result_high, condition_true, overflow
    output logic [mieu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    mieu_pkg::item_t       head;
    logic                  head_valid;
    logic                  pop;
    mieu_pkg::front_stat_t stat;

    mieu_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pop           (pop),
        .head          (head),
        .head_valid    (head_valid),
        .stat          (stat)
    );

    mieu_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.count != 2'd0)
        else $error("pop from empty queue");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !s_axis_tready)
        else $error("transfer accepted into full queue");

    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !pop)
        else $error("queue drained while output stalled");

endmodule

// ----- sv/mieu_front.sv -----
module mieu_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation, operand_s, operand_t, immediate, shift_amount, zero pad
    input  logic [mieu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            pop,
    output mieu_pkg::item_t                 head,
    output logic                            head_valid,
    output mieu_pkg::front_stat_t           stat
);

    mieu_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    mieu_pkg::item_t in_item;

    always_comb
    begin
        in_item.operation    = s_axis_tdata[5:0];
        in_item.operand_s    = s_axis_tdata[37:6];
        in_item.operand_t    = s_axis_tdata[69:38];
        in_item.immediate    = s_axis_tdata[85:70];
        in_item.shift_amount = s_axis_tdata[90:86];
        in_item.kind         = mieu_pkg::classify(s_axis_tdata[5:0], s_axis_tdata[69:38]);
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head_valid    = (count_reg != 2'd0);
    assign head          = entry_reg[rd_ptr_reg];
    assign stat.count    = count_reg;
    assign stat.full     = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/mieu_back.sv -----
module mieu_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mieu_pkg::item_t                 head,
    input  logic                            head_valid,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_low, result_high, condition_true, overflow, zero pad
    output logic [mieu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int NSTG = mieu_pkg::LAST_STAGE + 1;

    mieu_pkg::stage_t stage_reg  [NSTG];
    mieu_pkg::stage_t stage_next [NSTG];
    logic [NSTG-1:0]  valid_reg;
    logic             en;

    assign en  = !valid_reg[NSTG-1] || m_axis_tready;
    assign pop = en && head_valid;

    always_comb
    begin
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] se;
        logic [31:0] sum;
        logic [31:0] dif;
        logic        ovf;
        logic        sgn;
        s   = head.operand_s;
        t   = head.operand_t;
        se  = {{16{head.immediate[15]}}, head.immediate};
        sum = '0;
        dif = '0;
        ovf = 1'b0;
        sgn = 1'b0;
        stage_next[0] = '0;
        stage_next[0].kind = head.kind;
        unique case (head.operation)
            mieu_pkg::OP_ADDU:  stage_next[0].lo = s + t;
            mieu_pkg::OP_AND:   stage_next[0].lo = s & t;
            mieu_pkg::OP_OR:    stage_next[0].lo = s | t;
            mieu_pkg::OP_SLTU:  stage_next[0].lo = {31'd0, s < t};
            mieu_pkg::OP_SUBU:  stage_next[0].lo = s - t;
            mieu_pkg::OP_XOR:   stage_next[0].lo = s ^ t;
            mieu_pkg::OP_ADD, mieu_pkg::OP_ADDI:
            begin
                sum = (head.operation == mieu_pkg::OP_ADD) ? s + t : s + se;
                ovf = (head.operation == mieu_pkg::OP_ADD)
                    ? ((s[31] ^ sum[31]) & (t[31] ^ sum[31]))
                    : ((s[31] ^ sum[31]) & (se[31] ^ sum[31]));
                stage_next[0].ovf = ovf;
                stage_next[0].lo  = ovf ? 32'd0 : sum;
            end
            mieu_pkg::OP_ADDIU: stage_next[0].lo = s + se;
            mieu_pkg::OP_ANDI:  stage_next[0].lo = s & {16'd0, head.immediate};
            mieu_pkg::OP_LUI:   stage_next[0].lo = {head.immediate, 16'd0};
            mieu_pkg::OP_ORI:   stage_next[0].lo = s | {16'd0, head.immediate};
            mieu_pkg::OP_XORI:  stage_next[0].lo = s ^ {16'd0, head.immediate};
            mieu_pkg::OP_SLL:   stage_next[0].lo = t << head.shift_amount;
            mieu_pkg::OP_SLT:   stage_next[0].lo = {31'd0, $signed(s) < $signed(t)};
            mieu_pkg::OP_SRA:   stage_next[0].lo = $unsigned($signed(t) >>> head.shift_amount);
            mieu_pkg::OP_SRAV:  stage_next[0].lo = $unsigned($signed(t) >>> s[4:0]);
            mieu_pkg::OP_SRL:   stage_next[0].lo = t >> head.shift_amount;
            mieu_pkg::OP_SUB:
            begin
                dif = s - t;
                ovf = (s[31] ^ t[31]) & (s[31] ^ dif[31]);
                stage_next[0].ovf = ovf;
                stage_next[0].lo  = ovf ? 32'd0 : dif;
            end
            mieu_pkg::OP_BEQ:   stage_next[0].cond = (s == t);
            mieu_pkg::OP_BGEZ, mieu_pkg::OP_BGEZAL: stage_next[0].cond = !s[31];
            mieu_pkg::OP_BLTZ, mieu_pkg::OP_BLTZAL: stage_next[0].cond = s[31];
            mieu_pkg::OP_BGTZ:  stage_next[0].cond = !s[31] && (s != '0);
            mieu_pkg::OP_BLEZ:  stage_next[0].cond = s[31] || (s == '0);
            mieu_pkg::OP_BNE:   stage_next[0].cond = (s != t);
            mieu_pkg::OP_SLTI:  stage_next[0].lo = {31'd0, $signed(s) < $signed(se)};
            mieu_pkg::OP_SLTIU: stage_next[0].lo = {31'd0, s < se};
            mieu_pkg::OP_SLLV:  stage_next[0].lo = t << s[4:0];
            mieu_pkg::OP_SRLV:  stage_next[0].lo = t >> s[4:0];
            mieu_pkg::OP_DIV, mieu_pkg::OP_DIVU, mieu_pkg::OP_MULT, mieu_pkg::OP_MULTU:
            begin
                sgn = (head.operation == mieu_pkg::OP_DIV) ||
                      (head.operation == mieu_pkg::OP_MULT);
                if (t == '0)
                begin
                    stage_next[0].hi = s;
                end
                else
                begin
                    stage_next[0].lo      = (sgn && s[31]) ? 32'd0 - s : s;
                    stage_next[0].divisor = (sgn && t[31]) ? 32'd0 - t : t;
                    stage_next[0].neg_q   = sgn && (s[31] ^ t[31]);
                    stage_next[0].neg_r   = sgn && s[31];
                end
            end
            mieu_pkg::OP_JR:    stage_next[0].cond = (s[1:0] == 2'd0);
            default:            stage_next[0].lo = '0;
        endcase
    end

    for (genvar k = 1; k <= mieu_pkg::DIV_STEPS; k++)
    begin : g_step
        always_comb
        begin
            logic [32:0] shifted;
            logic [32:0] diff;
            logic [63:0] prod;
            shifted = {stage_reg[k-1].rem[31:0], stage_reg[k-1].lo[31]};
            diff    = shifted - {1'b0, stage_reg[k-1].divisor};
            prod    = '0;
            stage_next[k] = stage_reg[k-1];
            if (stage_reg[k-1].kind == mieu_pkg::KIND_DIV)
            begin
                if (!diff[32])
                begin
                    stage_next[k].rem = diff;
                    stage_next[k].lo  = {stage_reg[k-1].lo[30:0], 1'b1};
                end
                else
                begin
                    stage_next[k].rem = shifted;
                    stage_next[k].lo  = {stage_reg[k-1].lo[30:0], 1'b0};
                end
            end
            else if (stage_reg[k-1].kind == mieu_pkg::KIND_MUL && k == 1)
            begin
                prod = stage_reg[k-1].lo * stage_reg[k-1].divisor;
                {stage_next[k].hi, stage_next[k].lo} = prod;
            end
            else if (stage_reg[k-1].kind == mieu_pkg::KIND_MUL && k == 2 &&
                     stage_reg[k-1].neg_q)
            begin
                prod = 64'd0 - {stage_reg[k-1].hi, stage_reg[k-1].lo};
                {stage_next[k].hi, stage_next[k].lo} = prod;
            end
        end
    end

    always_comb
    begin
        stage_next[NSTG-1] = stage_reg[NSTG-2];
        if (stage_reg[NSTG-2].kind == mieu_pkg::KIND_DIV)
        begin
            stage_next[NSTG-1].lo = stage_reg[NSTG-2].neg_q ? 32'd0 - stage_reg[NSTG-2].lo
                                                             : stage_reg[NSTG-2].lo;
            stage_next[NSTG-1].hi = stage_reg[NSTG-2].neg_r
                                  ? 32'd0 - stage_reg[NSTG-2].rem[31:0]
                                  : stage_reg[NSTG-2].rem[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], head_valid};
        end
    end

    assign m_axis_tvalid = valid_reg[NSTG-1];
    assign m_axis_tdata  = {6'd0, stage_reg[NSTG-1].ovf, stage_reg[NSTG-1].cond,
                            stage_reg[NSTG-1].hi, stage_reg[NSTG-1].lo};

endmodule
